// ----- hdl/sdft_pkg.sv -----
// Package for the signed floored/truncating divider.
// Width, status codes, port word types and pipeline stage records.
// No dependencies.
`default_nettype none
package sdft_pkg;

  localparam int unsigned WIDTH = 32;

  typedef logic [WIDTH-1:0] uword_t;

  localparam uword_t MSB_ONLY = {1'b1, {(WIDTH-1){1'b0}}};
  localparam uword_t ALL_ONES = {WIDTH{1'b1}};

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DIV0 = 2'd1;
  localparam status_t ST_OVF  = 2'd2;

  localparam logic MODE_FLOOR = 1'b0;

  typedef struct packed {
    logic                    mode;
    logic signed [WIDTH-1:0] dividend;
    logic signed [WIDTH-1:0] divisor;
  } in_word_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic signed [WIDTH-1:0] remainder;
    status_t                 status;
  } out_word_t;

  // one record of the iterative part of the pipe
  typedef struct packed {
    logic   mode;
    logic   sa;
    logic   sb;
    logic   dz;
    logic   ovf;
    uword_t b;    // original divisor, needed by the floor fixup
    uword_t ub;   // divisor magnitude
    uword_t rem;  // partial remainder
    uword_t quo;  // dividend bits shifting out, quotient bits shifting in
  } div_stage_t;

  typedef struct packed {
    logic   fix;
    logic   dz;
    logic   ovf;
    uword_t b;
    uword_t q;
    uword_t r;
  } fix_stage_t;

endpackage
`default_nettype wire

// ----- hdl/signed_divider_floor_trunc.sv -----
// Signed divider, floored or truncating. One word is accepted per cycle
// while in_stall is low; the pipe is one register per quotient bit plus
// sign prep, sign restore and floor fixup.
// A stalled output holds only the stages behind it: bubbles are squeezed out.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`default_nettype none
module signed_divider_floor_trunc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sdft_pkg::in_word_t in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sdft_pkg::out_word_t     out_word
);

  localparam int unsigned W   = sdft_pkg::WIDTH;
  localparam int unsigned NST = W + 3;  // prep, W steps, sign restore, output

  logic [NST-1:0]       vld;
  logic [NST-1:0]       adv;
  sdft_pkg::div_stage_t st [W+1];

  // a stage may load when it or any stage ahead of it is empty, or output moves
  logic adv_last;
  assign adv_last = !vld[NST-1] || !out_stall;

  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = adv_last || !(&vld[NST-1:k]);
  end

  assign in_stall = !adv[0];

  // prep: magnitudes and special cases
  sdft_pkg::div_stage_t prep_nxt;
  sdft_pkg::uword_t     a_u;
  sdft_pkg::uword_t     b_u;

  always_comb begin
    a_u           = sdft_pkg::uword_t'(in_word.dividend);
    b_u           = sdft_pkg::uword_t'(in_word.divisor);
    prep_nxt.mode = in_word.mode;
    prep_nxt.sa   = a_u[W-1];
    prep_nxt.sb   = b_u[W-1];
    prep_nxt.dz   = (b_u == '0);
    prep_nxt.ovf  = (a_u == sdft_pkg::MSB_ONLY) && (b_u == sdft_pkg::ALL_ONES);
    prep_nxt.b    = b_u;
    prep_nxt.ub   = b_u[W-1] ? (~b_u + 1'b1) : b_u;
    prep_nxt.rem  = '0;
    prep_nxt.quo  = a_u[W-1] ? (~a_u + 1'b1) : a_u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0] <= prep_nxt;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_step
    sdft_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv[j]),
      .in_vld (vld[j-1]),
      .in_st  (st[j-1]),
      .vld_r  (vld[j]),
      .st_r   (st[j])
    );
  end

  // sign restore
  sdft_pkg::fix_stage_t fix_nxt;
  sdft_pkg::fix_stage_t fix_r;
  logic                 sdiff;

  always_comb begin
    sdiff       = st[W].sa ^ st[W].sb;
    fix_nxt.q   = sdiff ? (~st[W].quo + 1'b1) : st[W].quo;
    fix_nxt.r   = st[W].sa ? (~st[W].rem + 1'b1) : st[W].rem;
    fix_nxt.fix = (st[W].mode == sdft_pkg::MODE_FLOOR) && (st[W].rem != '0) && sdiff;
    fix_nxt.dz  = st[W].dz;
    fix_nxt.ovf = st[W].ovf;
    fix_nxt.b   = st[W].b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[W+1] <= 1'b0;
    end else if (adv[W+1]) begin
      vld[W+1] <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[W+1]) begin
      fix_r <= fix_nxt;
    end
  end

  // floor fixup and special-case override into the output register
  sdft_pkg::out_word_t out_nxt;
  sdft_pkg::out_word_t out_r;

  always_comb begin
    if (fix_r.dz) begin
      out_nxt.quotient  = '0;
      out_nxt.remainder = '0;
      out_nxt.status    = sdft_pkg::ST_DIV0;
    end else begin
      out_nxt.quotient  = $signed(fix_r.q - sdft_pkg::uword_t'(fix_r.fix));
      out_nxt.remainder = $signed(fix_r.r + (fix_r.fix ? fix_r.b : '0));
      out_nxt.status    = fix_r.ovf ? sdft_pkg::ST_OVF : sdft_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[NST-1] <= 1'b0;
    end else if (adv[NST-1]) begin
      vld[NST-1] <= vld[W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld[NST-1];
  assign out_word  = out_r;

endmodule
`default_nettype wire

// ----- hdl/sdft_step.sv -----
// One restoring division step as a registered pipeline stage.
// Depends on sdft_pkg.
`default_nettype none
module sdft_step (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_vld,
  input  wire sdft_pkg::div_stage_t in_st,
  output logic                     vld_r,
  output sdft_pkg::div_stage_t     st_r
);

  logic [sdft_pkg::WIDTH:0] sh;
  logic [sdft_pkg::WIDTH:0] diff;
  sdft_pkg::div_stage_t     st_nxt;

  always_comb begin
    sh     = {in_st.rem, in_st.quo[sdft_pkg::WIDTH-1]};
    diff   = sh - {1'b0, in_st.ub};
    st_nxt = in_st;
    if (!diff[sdft_pkg::WIDTH]) begin
      st_nxt.rem = diff[sdft_pkg::WIDTH-1:0];
      st_nxt.quo = {in_st.quo[sdft_pkg::WIDTH-2:0], 1'b1};
    end else begin
      st_nxt.rem = sh[sdft_pkg::WIDTH-1:0];
      st_nxt.quo = {in_st.quo[sdft_pkg::WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sdft_checker.sv -----
// Port-level checks for signed_divider_floor_trunc, bound to the top level.
// Depends on sdft_pkg.
`default_nettype none
module sdft_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire sdft_pkg::out_word_t out_word
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == sdft_pkg::ST_DIV0) |->
      (out_word.quotient == '0) && (out_word.remainder == '0))
    else $error("divide by zero word not cleared");

  a_ovf_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == sdft_pkg::ST_OVF) |->
      (sdft_pkg::uword_t'(out_word.quotient) == sdft_pkg::MSB_ONLY) &&
      (out_word.remainder == '0))
    else $error("overflow word wrong");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == sdft_pkg::ST_OK) ||
      (out_word.status == sdft_pkg::ST_DIV0) || (out_word.status == sdft_pkg::ST_OVF))
    else $error("undefined status code");

endmodule

bind signed_divider_floor_trunc sdft_checker u_sdft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

// ----- tb/sv/signed_divider_floor_trunc_checker.sv -----
// Checker for the signed floored/truncating divider: watches both channels,
// predicts each result word and compares it field by field. Needs sdft_pkg.
`timescale 1ns / 1ps
module signed_divider_floor_trunc_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire sdft_pkg::in_word_t  in_word,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire sdft_pkg::out_word_t out_word,
  output int                       errors,
  output int                       pending,
  output int                       results_seen,
  output int                       div0_seen,
  output int                       ovf_seen
);

  sdft_pkg::out_word_t quot_rem_q[$];

  // Unsigned magnitude division, then signs restored; floored mode pulls
  // the quotient down when the remainder sign disagrees with the divisor.
  function automatic sdft_pkg::out_word_t divide_word(sdft_pkg::in_word_t w);
    sdft_pkg::uword_t    a, b, ua, ub, uq, ur, q, r;
    logic                sa, sb;
    sdft_pkg::out_word_t o;
    a  = w.dividend;
    b  = w.divisor;
    sa = a[sdft_pkg::WIDTH-1];
    sb = b[sdft_pkg::WIDTH-1];
    if (b == '0) begin
      o.quotient  = '0;
      o.remainder = '0;
      o.status    = sdft_pkg::ST_DIV0;
      return o;
    end
    ua = sa ? sdft_pkg::uword_t'(0) - a : a;
    ub = sb ? sdft_pkg::uword_t'(0) - b : b;
    uq = ua / ub;
    ur = ua % ub;
    q  = (sa != sb) ? sdft_pkg::uword_t'(0) - uq : uq;
    r  = sa ? sdft_pkg::uword_t'(0) - ur : ur;
    o.status = (a == sdft_pkg::MSB_ONLY && b == sdft_pkg::ALL_ONES) ?
               sdft_pkg::ST_OVF : sdft_pkg::ST_OK;
    if (w.mode == sdft_pkg::MODE_FLOOR && ur != '0 && sa != sb) begin
      q = q - 1'b1;
      r = r + b;
    end
    o.quotient  = q;
    o.remainder = r;
    return o;
  endfunction

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    div0_seen    = 0;
    ovf_seen     = 0;
  end

  always @(posedge clk) begin
    sdft_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (quot_rem_q.size() == 0) begin
          $error("result word with nothing outstanding: q=%0d r=%0d st=%0d",
                 out_word.quotient, out_word.remainder, out_word.status);
          errors++;
        end else begin
          want = quot_rem_q.pop_front();
          if (out_word.quotient !== want.quotient) begin
            $error("quotient: expected %0d, got %0d", want.quotient, out_word.quotient);
            errors++;
          end
          if (out_word.remainder !== want.remainder) begin
            $error("remainder: expected %0d, got %0d", want.remainder, out_word.remainder);
            errors++;
          end
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            errors++;
          end
          if (want.status == sdft_pkg::ST_DIV0) div0_seen++;
          if (want.status == sdft_pkg::ST_OVF) ovf_seen++;
        end
      end
      if (in_valid && !in_stall) quot_rem_q.push_back(divide_word(in_word));
      pending = quot_rem_q.size();
    end
  end

endmodule

// ----- tb/sv/signed_divider_floor_trunc_tb.sv -----
// Top of the divider testbench: clock, reset, stimulus and verdict.
// Depends on sdft_pkg, the divider and signed_divider_floor_trunc_checker.
`timescale 1ns / 1ps
module signed_divider_floor_trunc_tb;

  localparam logic             MODE_TRUNC     = 1'b1;
  localparam sdft_pkg::uword_t MAX_POS        = ~sdft_pkg::MSB_ONLY;
  localparam int               WORDS_PER_PASS = 257;
  localparam int               SETTLE_CYCLES  = 40;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sdft_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  sdft_pkg::out_word_t out_word;

  int errors, pending, results_seen, div0_seen, ovf_seen;
  int idle_pct, stall_pct;

  signed_divider_floor_trunc uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  signed_divider_floor_trunc_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .div0_seen    (div0_seen),
    .ovf_seen     (ovf_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // hold the word until it is taken, return on the following falling edge
  task automatic send_word(sdft_pkg::in_word_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_both_modes(sdft_pkg::uword_t a, sdft_pkg::uword_t b);
    sdft_pkg::in_word_t w;
    w.dividend = a;
    w.divisor  = b;
    w.mode     = sdft_pkg::MODE_FLOOR;
    send_word(w);
    w.mode     = MODE_TRUNC;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic sdft_pkg::uword_t pick_operand();
    sdft_pkg::uword_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = sdft_pkg::uword_t'(1);
          2:       v = sdft_pkg::ALL_ONES;
          3:       v = sdft_pkg::MSB_ONLY;
          4:       v = MAX_POS;
          default: v = sdft_pkg::MSB_ONLY + 1'b1;
        endcase
      end
      1, 2: begin
        v = sdft_pkg::uword_t'($urandom_range(0, 40));
        if ($urandom_range(0, 1)) v = sdft_pkg::uword_t'(0) - v;
      end
      3, 4, 5: v = sdft_pkg::uword_t'({$urandom, $urandom});
      default: begin
        v = sdft_pkg::uword_t'({$urandom, $urandom}) >>
            $urandom_range(0, sdft_pkg::WIDTH - 1);
        if ($urandom_range(0, 1)) v = sdft_pkg::uword_t'(0) - v;
      end
    endcase
    return v;
  endfunction

  initial begin
    sdft_pkg::in_word_t w;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sign combinations, exact division, zero divisor, most negative cases
    send_both_modes(7, 2);
    send_both_modes(sdft_pkg::uword_t'(-7), 2);
    send_both_modes(7, sdft_pkg::uword_t'(-2));
    send_both_modes(sdft_pkg::uword_t'(-7), sdft_pkg::uword_t'(-2));
    send_both_modes(6, sdft_pkg::uword_t'(-3));
    send_both_modes(0, sdft_pkg::uword_t'(-3));
    send_both_modes(5, 0);
    send_both_modes(sdft_pkg::MSB_ONLY, sdft_pkg::ALL_ONES);
    send_both_modes(sdft_pkg::MSB_ONLY, 1);
    send_both_modes(MAX_POS, sdft_pkg::MSB_ONLY);
    send_both_modes(sdft_pkg::MSB_ONLY, sdft_pkg::MSB_ONLY);
    send_both_modes(sdft_pkg::ALL_ONES, MAX_POS);
    drain();

    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 54; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      repeat (WORDS_PER_PASS) begin
        maybe_idle();
        w.mode     = 1'($urandom_range(0, 1));
        w.dividend = pick_operand();
        w.divisor  = pick_operand();
        send_word(w);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("checked %0d result words (%0d divide by zero, %0d overflow)",
             results_seen, div0_seen, ovf_seen);
    $display("directed corners plus random operands in both modes, four pacing passes");
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
